FILE: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the checker module.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME_CYCLE(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT_CYCLE(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: sv/fdg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdg_pkg
// Types and constants shared by the difference gradient blocks.
// ----------------------------------------------------------------------------
package fdg_pkg;

   localparam int PIX_W     = 8;
   localparam int COORD_W   = 9;
   localparam int DIM_W     = 10;
   localparam int CSR_IDX_W = 2;
   localparam int RES_W     = 3;

   localparam logic [DIM_W-1:0] DIM_RESET   = 10'd512;
   localparam logic [PIX_W-1:0] ZERO_GRAD   = 8'd172;
   localparam logic [PIX_W-1:0] GRAD_OFFSET = 8'd45;
   localparam logic [PIX_W:0]   GRAD_SPAN   = 9'd255;

   // Bit positions of the result mask, in emission order.
   localparam int RES_ABOVE     = 0;
   localparam int RES_LAST_ROW  = 1;
   localparam int RES_FRAME_END = 2;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_IMAGE_WIDTH  = 2'd0,
      CSR_IMAGE_HEIGHT = 2'd1
   } fdg_csr_type;

   typedef struct packed {
      logic [RES_W-1:0]   res_mask;
      logic [COORD_W-1:0] row;
      logic [COORD_W-1:0] col;
      logic [PIX_W-1:0]   above_hgrad;
      logic [PIX_W-1:0]   above_vgrad;
      logic [PIX_W-1:0]   left_hgrad;
   } fdg_set_type;

   function automatic logic [PIX_W-1:0] grad_map(input logic [PIX_W-1:0] a,
                                                 input logic [PIX_W-1:0] b);
      logic [PIX_W:0] s;
      s = {1'b0, a} + GRAD_SPAN - {1'b0, b};
      return s[PIX_W:1] + GRAD_OFFSET;
   endfunction

endpackage

FILE: sv/fdg_line_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdg_line_mem
// One-row line store with a registered read port and write-to-read forwarding.
// ----------------------------------------------------------------------------
module fdg_line_mem #(
   parameter int DEPTH = 512
) (
   input  logic                       clock,
   input  logic                       wr_en,
   input  logic [$clog2(DEPTH)-1:0]   wr_addr,
   input  logic [fdg_pkg::PIX_W-1:0]  wr_data,
   input  logic                       rd_en,
   input  logic [$clog2(DEPTH)-1:0]   rd_addr,
   output logic [fdg_pkg::PIX_W-1:0]  rd_data
);
   import fdg_pkg::*;

   logic [PIX_W-1:0] mem_ff [DEPTH];
   logic [PIX_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         if (wr_en && (wr_addr == rd_addr)) begin
            rd_data_ff <= wr_data;
         end else begin
            rd_data_ff <= mem_ff[rd_addr];
         end
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: sv/fdg_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdg_front
// Configuration registers, raster counters, line store addressing and the
// gradient stage that turns one pixel into its set of results.
// ----------------------------------------------------------------------------
module fdg_front #(
   parameter int MAX_WIDTH  = 512,
   parameter int MAX_HEIGHT = 512
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [fdg_pkg::PIX_W-1:0]       req_pixel,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [fdg_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [fdg_pkg::DIM_W-1:0]       csr_wdata,
   output logic                            mem_wr_en,
   output logic [$clog2(MAX_WIDTH)-1:0]    mem_wr_addr,
   output logic [fdg_pkg::PIX_W-1:0]       mem_wr_data,
   output logic                            mem_rd_en,
   output logic [$clog2(MAX_WIDTH)-1:0]    mem_rd_addr,
   input  logic [fdg_pkg::PIX_W-1:0]       mem_rd_data,
   output logic                            set_valid,
   output fdg_pkg::fdg_set_type            set_data,
   input  logic                            set_take
);
   import fdg_pkg::*;

   localparam int CW  = $clog2(MAX_WIDTH);
   localparam int RW  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
   localparam int WEW = $clog2(MAX_WIDTH + 1);
   localparam int HEW = $clog2(MAX_HEIGHT + 1);

   logic [DIM_W-1:0] width_reg_ff, width_reg_in;
   logic [DIM_W-1:0] height_reg_ff, height_reg_in;
   logic [CW-1:0]    col_ff, col_in;
   logic [RW-1:0]    row_ff, row_in;
   logic [PIX_W-1:0] prev_ff, prev_in;
   logic             s1_valid_ff, s1_valid_in;

   logic [PIX_W-1:0]   s1_pixel_ff;
   logic [PIX_W-1:0]   s1_prev_ff;
   logic [COORD_W-1:0] s1_row_ff;
   logic [COORD_W-1:0] s1_col_ff;
   logic [RES_W-1:0]   s1_mask_ff;
   logic               s1_last_col_ff;
   logic [PIX_W-1:0]   above_ff;

   logic [WEW-1:0] w_eff;
   logic [HEW-1:0] h_eff;
   logic [CW-1:0]  w_m1;
   logic [RW-1:0]  h_m1;
   logic           accept;
   logic           s1_move;
   logic           last_col;
   logic           last_row;
   logic           restart;
   logic [RES_W-1:0] mask_new;

   always_comb begin
      if (width_reg_ff == '0) begin
         w_eff = WEW'(1);
      end else if (32'(width_reg_ff) > 32'(MAX_WIDTH)) begin
         w_eff = WEW'(MAX_WIDTH);
      end else begin
         w_eff = WEW'(width_reg_ff);
      end
      if (height_reg_ff == '0) begin
         h_eff = HEW'(1);
      end else if (32'(height_reg_ff) > 32'(MAX_HEIGHT)) begin
         h_eff = HEW'(MAX_HEIGHT);
      end else begin
         h_eff = HEW'(height_reg_ff);
      end
   end

   assign w_m1 = CW'(w_eff - WEW'(1));
   assign h_m1 = RW'(h_eff - HEW'(1));

   assign last_col  = (col_ff == w_m1);
   assign last_row  = (row_ff == h_m1);
   assign s1_move   = s1_valid_ff && set_take;
   assign req_ready = !s1_valid_ff || set_take;
   assign accept    = req_valid && req_ready;
   assign csr_ready = 1'b1;

   assign mask_new[RES_ABOVE]     = (row_ff != '0);
   assign mask_new[RES_LAST_ROW]  = last_row && (col_ff != '0);
   assign mask_new[RES_FRAME_END] = last_row && last_col;

   assign mem_wr_en   = accept;
   assign mem_wr_addr = col_ff;
   assign mem_wr_data = req_pixel;
   assign mem_rd_en   = accept;
   assign mem_rd_addr = last_col ? '0 : col_ff + CW'(1);

   always_comb begin
      width_reg_in  = width_reg_ff;
      height_reg_in = height_reg_ff;
      col_in        = col_ff;
      row_in        = row_ff;
      prev_in       = prev_ff;
      restart       = 1'b0;
      if (accept) begin
         prev_in = req_pixel;
         if (last_col) begin
            col_in = '0;
            row_in = last_row ? '0 : row_ff + RW'(1);
         end else begin
            col_in = col_ff + CW'(1);
         end
      end
      if (csr_valid) begin
         case (csr_index)
            CSR_IMAGE_WIDTH: begin
               width_reg_in = csr_wdata;
               restart      = 1'b1;
            end
            CSR_IMAGE_HEIGHT: begin
               height_reg_in = csr_wdata;
               restart       = 1'b1;
            end
            default: begin
               restart = 1'b0;
            end
         endcase
      end
      if (restart) begin
         col_in  = '0;
         row_in  = '0;
         prev_in = '0;
      end
   end

   always_comb begin
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_move) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_reg_ff  <= DIM_RESET;
         height_reg_ff <= DIM_RESET;
         col_ff        <= '0;
         row_ff        <= '0;
         prev_ff       <= '0;
         s1_valid_ff   <= 1'b0;
      end else begin
         width_reg_ff  <= width_reg_in;
         height_reg_ff <= height_reg_in;
         col_ff        <= col_in;
         row_ff        <= row_in;
         prev_ff       <= prev_in;
         s1_valid_ff   <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_pixel_ff    <= req_pixel;
         s1_prev_ff     <= prev_ff;
         s1_row_ff      <= COORD_W'(row_ff);
         s1_col_ff      <= COORD_W'(col_ff);
         s1_mask_ff     <= mask_new;
         s1_last_col_ff <= last_col;
      end
      if (s1_move) begin
         above_ff <= mem_rd_data;
      end
   end

   // The read issued with a pixel returns the stored pixel one column to the
   // right; above_ff holds the stored pixel of the current column.
   always_comb begin
      set_data.res_mask    = s1_mask_ff;
      set_data.row         = s1_row_ff;
      set_data.col         = s1_col_ff;
      set_data.above_hgrad = s1_last_col_ff ? ZERO_GRAD : grad_map(above_ff, mem_rd_data);
      set_data.above_vgrad = grad_map(above_ff, s1_pixel_ff);
      set_data.left_hgrad  = grad_map(s1_prev_ff, s1_pixel_ff);
   end

   assign set_valid = s1_valid_ff;

endmodule

FILE: sv/fdg_out.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdg_out
// Output register holding one pixel's result set and sending its results one
// transaction at a time.
// ----------------------------------------------------------------------------
module fdg_out (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          set_valid,
   input  fdg_pkg::fdg_set_type          set_data,
   output logic                          set_take,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [fdg_pkg::COORD_W-1:0]   rsp_out_row,
   output logic [fdg_pkg::COORD_W-1:0]   rsp_out_col,
   output logic [fdg_pkg::PIX_W-1:0]     rsp_horizontal_grad,
   output logic [fdg_pkg::PIX_W-1:0]     rsp_vertical_grad,
   output logic                          rsp_frame_last
);
   import fdg_pkg::*;

   logic [RES_W-1:0] mask_ff, mask_in;
   fdg_set_type      hold_ff;
   logic             fire;
   logic             load;
   logic [RES_W-1:0] low_bit;

   assign rsp_valid = (mask_ff != '0);
   assign fire      = rsp_valid && rsp_ready;
   assign low_bit   = mask_ff & (~mask_ff + RES_W'(1));
   assign set_take  = (mask_ff == '0) || (rsp_ready && (mask_ff == low_bit));
   assign load      = set_valid && set_take;

   always_comb begin
      mask_in = mask_ff;
      if (fire) begin
         mask_in = mask_ff & ~low_bit;
      end
      if (load) begin
         mask_in = set_data.res_mask;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff <= '0;
      end else begin
         mask_ff <= mask_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         hold_ff <= set_data;
      end
   end

   always_comb begin
      if (mask_ff[RES_ABOVE]) begin
         rsp_out_row         = hold_ff.row - COORD_W'(1);
         rsp_out_col         = hold_ff.col;
         rsp_horizontal_grad = hold_ff.above_hgrad;
         rsp_vertical_grad   = hold_ff.above_vgrad;
         rsp_frame_last      = 1'b0;
      end else if (mask_ff[RES_LAST_ROW]) begin
         rsp_out_row         = hold_ff.row;
         rsp_out_col         = hold_ff.col - COORD_W'(1);
         rsp_horizontal_grad = hold_ff.left_hgrad;
         rsp_vertical_grad   = ZERO_GRAD;
         rsp_frame_last      = 1'b0;
      end else begin
         rsp_out_row         = hold_ff.row;
         rsp_out_col         = hold_ff.col;
         rsp_horizontal_grad = ZERO_GRAD;
         rsp_vertical_grad   = ZERO_GRAD;
         rsp_frame_last      = 1'b1;
      end
   end

endmodule

FILE: sv/first_difference_gradient_image_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// first_difference_gradient_image_core
// Streaming first-order difference gradient of an 8-bit grayscale image.
//
// Channel   Direction  Handshake          Payload
// req_      in         req_valid/ready    pixel
// rsp_      out        rsp_valid/ready    out_row, out_col, horizontal_grad,
//                                         vertical_grad, frame_last
// csr_      in         csr_valid/ready    index, wdata (image_width, height)
//
// One pixel is accepted per cycle; its results pass through the stage-one and
// output registers. The single result port sets the rate on the last row: up
// to two results per pixel there, up to three on the final pixel of a frame.
// The line store reads once and writes once per pixel, so the inner rows run
// at one pixel per cycle. Synchronous reset; no clearing pass is needed.
// A stall on rsp_ready holds the result and backs up into req_ready.
// ----------------------------------------------------------------------------
module first_difference_gradient_image_core #(
   parameter int MAX_WIDTH  = 512,
   parameter int MAX_HEIGHT = 512
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [fdg_pkg::PIX_W-1:0]       req_pixel,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [fdg_pkg::COORD_W-1:0]     rsp_out_row,
   output logic [fdg_pkg::COORD_W-1:0]     rsp_out_col,
   output logic [fdg_pkg::PIX_W-1:0]       rsp_horizontal_grad,
   output logic [fdg_pkg::PIX_W-1:0]       rsp_vertical_grad,
   output logic                            rsp_frame_last,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [fdg_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [fdg_pkg::DIM_W-1:0]       csr_wdata
);
   import fdg_pkg::*;

   localparam int CW = $clog2(MAX_WIDTH);

   logic             mem_wr_en;
   logic [CW-1:0]    mem_wr_addr;
   logic [PIX_W-1:0] mem_wr_data;
   logic             mem_rd_en;
   logic [CW-1:0]    mem_rd_addr;
   logic [PIX_W-1:0] mem_rd_data;
   logic             set_valid;
   fdg_set_type      set_data;
   logic             set_take;

   fdg_line_mem #(
      .DEPTH (MAX_WIDTH)
   ) u_line_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   fdg_front #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_pixel   (req_pixel),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .mem_wr_en   (mem_wr_en),
      .mem_wr_addr (mem_wr_addr),
      .mem_wr_data (mem_wr_data),
      .mem_rd_en   (mem_rd_en),
      .mem_rd_addr (mem_rd_addr),
      .mem_rd_data (mem_rd_data),
      .set_valid   (set_valid),
      .set_data    (set_data),
      .set_take    (set_take)
   );

   fdg_out u_out (
      .clock               (clock),
      .reset               (reset),
      .set_valid           (set_valid),
      .set_data            (set_data),
      .set_take            (set_take),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_out_row         (rsp_out_row),
      .rsp_out_col         (rsp_out_col),
      .rsp_horizontal_grad (rsp_horizontal_grad),
      .rsp_vertical_grad   (rsp_vertical_grad),
      .rsp_frame_last      (rsp_frame_last)
   );

endmodule

FILE: sv/fdg_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdg_checker
// Port-level checks on the difference gradient core, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module fdg_checker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_ready,
   input  logic                            rsp_valid,
   input  logic                            rsp_ready,
   input  logic [fdg_pkg::COORD_W-1:0]     rsp_out_row,
   input  logic [fdg_pkg::COORD_W-1:0]     rsp_out_col,
   input  logic [fdg_pkg::PIX_W-1:0]       rsp_horizontal_grad,
   input  logic [fdg_pkg::PIX_W-1:0]       rsp_vertical_grad,
   input  logic                            rsp_frame_last
);
   import fdg_pkg::*;

   `ASSERT_NEXT_CYCLE(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid, "rsp_valid dropped before its transaction")
   `ASSERT_NEXT_CYCLE(a_rsp_stable, clock, reset, rsp_valid && !rsp_ready, $stable(rsp_out_row) && $stable(rsp_out_col) && $stable(rsp_horizontal_grad) && $stable(rsp_vertical_grad) && $stable(rsp_frame_last), "stalled result changed")
   `ASSERT_SAME_CYCLE(a_frame_end_flat, clock, reset, rsp_valid && rsp_frame_last, (rsp_horizontal_grad == ZERO_GRAD) && (rsp_vertical_grad == ZERO_GRAD), "frame end result carries a nonzero gradient")
   `ASSERT_SAME_CYCLE(a_reset_empty, clock, reset, $past(reset), req_ready && !rsp_valid, "pipeline not empty after reset")

endmodule

bind first_difference_gradient_image_core fdg_checker u_fdg_checker (.*);
